FILE: rtl/shs_pkg.sv
// Shared types, constants and round tables for the SHA-256 stream hasher.
package shs_pkg;

  localparam int unsigned QueueDepth = 16;

  localparam logic [7:0] PadByte = 8'h80;

  // Word handed from the front end to the compression core
  typedef struct packed {
    logic [31:0] word;
    logic        final_word;
  } shs_word_t;

  typedef enum logic {
    F_ABSORB,
    F_PAD
  } front_state_t;

  typedef enum logic [1:0] {
    C_LOAD,
    C_SCHED,
    C_ADD
  } core_state_t;

  // Initial hash value, word i
  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] r;
    unique case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      3'd7: r = 32'h5be0cd19;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Round constant for round t
  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] r;
    unique case (t)
      6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/shs_front.sv
// Front end: packs message bytes into words and generates the padding words.
module shs_front
  import shs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             kind,
  input  logic [7:0]       data_byte,
  output logic             q_push,
  output shs_word_t        q_entry,
  input  logic             q_full
);

  front_state_t state, state_next;
  logic [63:0]  bits;
  logic [63:0]  len;
  logic [31:0]  acc;
  logic [31:0]  pad_word;
  logic [3:0]   widx;
  logic         first;
  logic         extra;
  logic [1:0]   lane;
  logic         take;

  assign lane = bits[4:3];
  assign full = (state != F_ABSORB) || q_full;
  assign take = push && !full;

  // Partial word with the pad byte placed after the last message byte
  always_comb begin
    case (lane)
      2'd0:    pad_word = {PadByte, 24'h0};
      2'd1:    pad_word = {acc[31:24], PadByte, 16'h0};
      2'd2:    pad_word = {acc[31:16], PadByte, 8'h0};
      default: pad_word = {acc[31:8], PadByte};
    endcase
  end

  // Next state and word output
  always_comb begin
    state_next       = state;
    q_push           = 1'b0;
    q_entry.word     = {acc[31:8], data_byte};
    q_entry.final_word = 1'b0;
    unique case (state)
      F_ABSORB: begin
        q_push = take && !kind && (lane == 2'd3);
        if (take && kind) begin
          state_next = F_PAD;
        end
      end
      F_PAD: begin
        q_push = !q_full;
        if (first) begin
          q_entry.word = acc;
        end else if (widx == 4'd14 && !extra) begin
          q_entry.word = len[63:32];
        end else if (widx == 4'd15 && !extra) begin
          q_entry.word = len[31:0];
        end else begin
          q_entry.word = 32'h0;
        end
        q_entry.final_word = (widx == 4'd15) && !extra;
        if (!q_full && widx == 4'd15 && !extra) begin
          state_next = F_ABSORB;
        end
      end
      default: state_next = F_ABSORB;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_ABSORB;
    end else begin
      state <= state_next;
    end
  end

  // Byte count, word assembly and padding sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      bits  <= 64'h0;
      first <= 1'b0;
      extra <= 1'b0;
      widx  <= 4'h0;
    end else if (state == F_ABSORB) begin
      if (take && !kind) begin
        acc[31 - 8 * lane -: 8] <= data_byte;
        bits <= bits + 64'd8;
      end else if (take) begin
        len   <= bits;
        acc   <= pad_word;
        widx  <= bits[8:5];
        first <= 1'b1;
        extra <= (bits[8:6] == 3'b111);
      end
    end else if (!q_full) begin
      first <= 1'b0;
      widx  <= widx + 4'd1;
      if (widx == 4'd15) begin
        extra <= 1'b0;
        if (!extra) begin
          bits <= 64'h0;
        end
      end
    end
  end

endmodule

FILE: rtl/shs_fifo.sv
// Word queue between the front end and the compression core.
module shs_fifo
  import shs_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  shs_word_t wr_data,
  output logic      q_full,
  input  logic      rd_en,
  output shs_word_t rd_data,
  output logic      q_empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  shs_word_t     slots [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign q_full  = (count == CW'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = slots[rptr];

  // Store a word
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(do_wr) - CW'(do_rd);
    end
  end

endmodule

FILE: rtl/shs_core.sv
// Compression core: one SHA-256 round per cycle while not waiting on an empty word queue, and the digest register.
module shs_core
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  shs_word_t   q_data,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] digest_0,
  output logic [63:0] digest_1,
  output logic [63:0] digest_2,
  output logic [63:0] digest_3
);

  core_state_t state, state_next;
  logic [5:0]  rnd;
  logic [31:0] win   [16];
  logic [31:0] v     [8];
  logic [31:0] chain [8];
  logic [31:0] sum   [8];
  logic [31:0] dig   [8];
  logic        fin;
  logic        dvalid;
  logic        step;
  logic        commit;
  logic [31:0] sched;
  logic [31:0] wt;
  logic [31:0] t1;
  logic [31:0] t2;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Message schedule and one round
  always_comb begin
    sched = win[0] + (ror(win[1], 7) ^ ror(win[1], 18) ^ (win[1] >> 3))
          + win[9] + (ror(win[14], 17) ^ ror(win[14], 19) ^ (win[14] >> 10));
    wt = (state == C_LOAD) ? q_data.word : sched;
    t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(rnd) + wt;
    t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    for (int i = 0; i < 8; i++) begin
      sum[i] = chain[i] + v[i];
    end
  end

  assign empty = !dvalid;

  // Next state and step control
  always_comb begin
    state_next = state;
    step       = 1'b0;
    commit     = 1'b0;
    q_pop      = 1'b0;
    unique case (state)
      C_LOAD: begin
        q_pop = !q_empty;
        step  = !q_empty;
        if (step && rnd == 6'd15) begin
          state_next = C_SCHED;
        end
      end
      C_SCHED: begin
        step = 1'b1;
        if (rnd == 6'd63) begin
          state_next = C_ADD;
        end
      end
      C_ADD: begin
        commit = !(fin && dvalid && !pop);
        if (commit) begin
          state_next = C_LOAD;
        end
      end
      default: state_next = C_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Schedule window, working variables and round counter
  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= 6'd0;
      fin <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        v[i]     <= init_hash(3'(i));
        chain[i] <= init_hash(3'(i));
      end
    end else if (step) begin
      rnd <= rnd + 6'd1;
      if (state == C_LOAD && rnd == 6'd15) begin
        fin <= q_data.final_word;
      end
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= wt;
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end else if (commit) begin
      for (int i = 0; i < 8; i++) begin
        v[i]     <= fin ? init_hash(3'(i)) : sum[i];
        chain[i] <= fin ? init_hash(3'(i)) : sum[i];
      end
    end
  end

  // Hold the digest until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid <= 1'b0;
    end else if (commit && fin) begin
      dvalid <= 1'b1;
    end else if (pop) begin
      dvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && fin) begin
      for (int i = 0; i < 8; i++) begin
        dig[i] <= sum[i];
      end
    end
  end

  assign digest_0 = {dig[0], dig[1]};
  assign digest_1 = {dig[2], dig[3]};
  assign digest_2 = {dig[4], dig[5]};
  assign digest_3 = {dig[6], dig[7]};

  a_sched_rnd: assert property (@(posedge clk) disable iff (rst)
    state == C_SCHED |-> rnd >= 6'd16)
    else $error("schedule phase entered before all block words loaded");

  a_load_rnd: assert property (@(posedge clk) disable iff (rst)
    state == C_LOAD |-> rnd <= 6'd15)
    else $error("load phase past word fifteen");

  a_final_iv: assert property (@(posedge clk) disable iff (rst)
    commit && fin |=> chain[0] == init_hash(3'd0) && chain[7] == init_hash(3'd7))
    else $error("chain value not restored after digest");

  a_add_rnd: assert property (@(posedge clk) disable iff (rst)
    state == C_ADD |-> rnd == 6'd0)
    else $error("round counter not wrapped at block end");

endmodule

FILE: rtl/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher.
//
//  Channel   Handshake            Fields
//  input     push / full          kind, data_byte
//  result    empty / pop          digest_0 .. digest_3
//
// A data byte is taken each cycle while the word queue has room and no padding is under way.
// For each 64-byte block, 16 rounds overlap word arrival, 48 more rounds run
// from the schedule window, then the C_ADD state adds the chain.
// A finish item holds full high while padding words are queued, and longer
// while the word queue is full; the digest appears after the last block's
// compression.
// rst is synchronous, clears all control state and loads the initial hash value into the chain.
// The core stalls when it waits for a word on an empty queue, or when a digest waits unread and another is ready.
module sha256_stream_hasher
  import shs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] digest_0,
  output logic [63:0] digest_1,
  output logic [63:0] digest_2,
  output logic [63:0] digest_3
);

  shs_word_t wr_data;
  shs_word_t rd_data;
  logic      wr_en;
  logic      q_full;
  logic      rd_en;
  logic      q_empty;

  shs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .data_byte (data_byte),
    .q_push    (wr_en),
    .q_entry   (wr_data),
    .q_full    (q_full)
  );

  shs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .q_full  (q_full),
    .rd_en   (rd_en),
    .rd_data (rd_data),
    .q_empty (q_empty)
  );

  shs_core u_core (
    .clk      (clk),
    .rst      (rst),
    .q_data   (rd_data),
    .q_empty  (q_empty),
    .q_pop    (rd_en),
    .empty    (empty),
    .pop      (pop),
    .digest_0 (digest_0),
    .digest_1 (digest_1),
    .digest_2 (digest_2),
    .digest_3 (digest_3)
  );

endmodule

FILE: test/tb_sha256_stream_hasher.sv
// Self-checking testbench for the SHA-256 stream hasher: byte stimulus, digest scoreboard.
module tb_sha256_stream_hasher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KindAbsorb = 1'b0;
  localparam logic KindFinish = 1'b1;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct {
    logic [63:0] word [4];
  } digest_t;

  // Scoreboard: running SHA-256 state plus queue of expected digests
  class digest_scoreboard;
    logic [31:0] chain [8];
    logic [7:0]  buffer [64];
    logic [63:0] bit_count;
    digest_t     pending [$];
    int          errors;

    function new();
      errors = 0;
      clear_state();
      foreach (buffer[i]) buffer[i] = 8'h00;
    endfunction

    function void clear_state();
      chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      bit_count = '0;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] k [64];
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      k = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
      for (int t = 0; t < 16; t++)
        w[t] = {buffer[4*t], buffer[4*t+1], buffer[4*t+2], buffer[4*t+3]};
      for (int t = 16; t < 64; t++) begin
        s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
        s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
        w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      v = chain;
      for (int t = 0; t < 64; t++) begin
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
             + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k[t] + w[t];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
             + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    // Note one accepted input transfer
    function void note_input(logic kind, logic [7:0] data);
      int pos;
      logic [63:0] len;
      digest_t d;
      pos = int'(bit_count[8:3]);
      len = bit_count;
      if (kind == KindAbsorb) begin
        buffer[pos] = data;
        bit_count += 64'd8;
        if (pos == 63) compress();
        return;
      end
      buffer[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin buffer[pos] = 8'h00; pos++; end
        compress();
        pos = 0;
      end
      while (pos < 56) begin buffer[pos] = 8'h00; pos++; end
      for (int i = 0; i < 8; i++) buffer[56+i] = len[63-8*i -: 8];
      compress();
      for (int i = 0; i < 4; i++) d.word[i] = {chain[2*i], chain[2*i+1]};
      pending.push_back(d);
      clear_state();
    endfunction

    function void report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endfunction

    // Check one accepted result transfer
    function void check_result(logic [63:0] got [4]);
      digest_t d;
      if (pending.size() == 0) begin
        report("digest with none expected");
        return;
      end
      d = pending.pop_front();
      for (int i = 0; i < 4; i++)
        if (got[i] !== d.word[i])
          report($sformatf("digest_%0d got %h want %h", i, got[i], d.word[i]));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic kind = KindAbsorb;
  logic [7:0] data_byte = 8'h00;
  logic pop = 1'b0;
  logic full, empty;
  logic [63:0] digest_0, digest_1, digest_2, digest_3;

  digest_scoreboard sb = new();
  int unsigned cycles = 0;
  bit hold_off = 1'b0;

  sha256_stream_hasher u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind),
    .data_byte(data_byte), .empty(empty), .pop(pop),
    .digest_0(digest_0), .digest_1(digest_1), .digest_2(digest_2), .digest_3(digest_3)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one item after a random gap; hold it until the transfer
  task automatic send_item(logic k, logic [7:0] b);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    kind <= k;
    data_byte <= b;
    do @(posedge clk); while (full);
    sb.note_input(k, b);
  endtask

  task automatic send_message(int n);
    for (int i = 0; i < n; i++) send_item(KindAbsorb, 8'($urandom));
    send_item(KindFinish, 8'($urandom));
  endtask

  // Receiver: random pop gap per digest, plus one long hold-off
  initial begin
    int gap;
    logic [63:0] got [4];
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 3);
      if (gap > 0 || hold_off) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got = '{digest_0, digest_1, digest_2, digest_3};
      sb.check_result(got);
    end
  end

  // Long receiver stall so queued digests back up into the input
  initial begin
    @(negedge rst);
    repeat (600) @(posedge clk);
    hold_off <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Stimulus
  initial begin
    int total;
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: empty message, byte extremes, padding boundaries, data on finish ignored
    send_item(KindFinish, 8'hff);
    send_item(KindAbsorb, 8'h00);
    send_item(KindAbsorb, 8'hff);
    send_item(KindFinish, 8'h00);
    send_message(55);
    send_message(56);
    send_message(63);
    send_message(64);
    total = 55 + 56 + 63 + 64 + 8;
    // Random messages, mostly short, a few spanning several blocks
    while (total < 1450) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 70);
      send_message(n);
      total += n + 1;
    end
    push <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (300) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
